// File: hdl/tcw_pkg.sv
// Package for the text console writer: item and command types, opcodes,
// sequencer states and default constants.
// No dependencies; used by every module of the block.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] NEWLINE_CODE       = 8'd10;
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd240;

    typedef enum logic [2:0] {
        OP_PUT_CURSOR = 3'd0,
        OP_PUT_CELL   = 3'd1,
        OP_BACKSPACE  = 3'd2,
        OP_COLOR      = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_READ       = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        K_NOP,
        K_PUT_CURSOR,
        K_PUT_CELL,
        K_BACKSPACE,
        K_COLOR,
        K_CLEAR,
        K_READ
    } t_kind;

    typedef enum logic [2:0] {
        BS_INIT,
        BS_IDLE,
        BS_EXEC,
        BS_SCROLL,
        BS_SWEEP_END,
        BS_CLEAR,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row_index;
        logic [7:0] attribute;
    } t_in_item;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } t_out_item;

    typedef struct packed {
        t_kind      kind;
        logic       is_newline;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row_index;
        logic [7:0] attribute;
    } t_cmd;

endpackage

// File: hdl/tcw_front.sv
// Front end of the text console writer: accepts items, classifies them into
// commands and holds them in a short queue; also holds the default attribute.
// Depends on tcw_pkg.
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcw_pkg::t_in_item   i_in_item,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    output logic                o_cmd_valid,
    output tcw_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_pop
);

    localparam int QPW = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(tcw_pkg::QUEUE_DEPTH + 1);
    localparam logic [QPW-1:0] PTR_LAST = QPW'(tcw_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] CNT_FULL = QCW'(tcw_pkg::QUEUE_DEPTH);

    logic [7:0]     r_default_attr;
    tcw_pkg::t_cmd  r_queue [tcw_pkg::QUEUE_DEPTH];
    logic [QPW-1:0] r_wr_ptr;
    logic [QPW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;

    tcw_pkg::t_cmd  n_cmd;
    logic           target_ok;
    logic           push;
    logic           pop;

    assign o_in_stall  = (r_count == CNT_FULL);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;

    assign target_ok = (32'(i_in_item.column) < COLUMNS) && (32'(i_in_item.row_index) < ROWS);

    always_comb begin
        n_cmd.is_newline = (i_in_item.char_code == tcw_pkg::NEWLINE_CODE);
        n_cmd.char_code  = i_in_item.char_code;
        n_cmd.column     = i_in_item.column;
        n_cmd.row_index  = i_in_item.row_index;
        n_cmd.attribute  = i_in_item.attribute;
        case (i_in_item.opcode)
            tcw_pkg::OP_PUT_CURSOR: n_cmd.kind = tcw_pkg::K_PUT_CURSOR;
            tcw_pkg::OP_PUT_CELL:   n_cmd.kind = target_ok ? tcw_pkg::K_PUT_CELL : tcw_pkg::K_NOP;
            tcw_pkg::OP_BACKSPACE:  n_cmd.kind = tcw_pkg::K_BACKSPACE;
            tcw_pkg::OP_COLOR:      n_cmd.kind = target_ok ? tcw_pkg::K_COLOR : tcw_pkg::K_NOP;
            tcw_pkg::OP_CLEAR:      n_cmd.kind = tcw_pkg::K_CLEAR;
            tcw_pkg::OP_READ:       n_cmd.kind = target_ok ? tcw_pkg::K_READ : tcw_pkg::K_NOP;
            default:                n_cmd.kind = tcw_pkg::K_NOP;
        endcase
        if (i_in_item.attribute == 8'd0) begin
            n_cmd.attribute = r_default_attr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= tcw_pkg::DEFAULT_ATTR_RESET;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_default_attr <= i_cfg_wr_data;
            end
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + QPW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + QPW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= n_cmd;
        end
    end

endmodule

// File: hdl/tcw_back.sv
// Back end of the text console writer: cell memories, cursor and the
// sequencer that executes commands, sweeps for clear and scroll, and
// the output register. Depends on tcw_pkg.
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  tcw_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcw_pkg::t_out_item  o_out_item
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_BASE = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

    tcw_pkg::t_bstate   r_state, n_state;
    tcw_pkg::t_cmd      r_cmd, n_cmd;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [AW-1:0]      r_base, n_base;
    logic [AW-1:0]      r_tbase, n_tbase;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic               r_d_valid, n_d_valid;
    logic               r_d_copy, n_d_copy;
    logic [AW-1:0]      r_d_addr, n_d_addr;
    logic               r_is_read, n_is_read;
    logic               r_scrolled, n_scrolled;
    logic [7:0]         r_rd_char;
    logic [7:0]         r_rd_attr;
    logic               r_out_valid;
    tcw_pkg::t_out_item r_out;

    logic [7:0]         r_mem_char [CELLS];
    logic [7:0]         r_mem_attr [CELLS];

    logic               char_we, attr_we, rd_en;
    logic [AW-1:0]      char_waddr, attr_waddr, rd_addr;
    logic [7:0]         char_wdata, attr_wdata;
    logic               load_out;

    logic [RW-1:0]      src_row;
    logic [CW-1:0]      src_col;
    logic [AW-1:0]      src_base;
    logic               step_line;
    logic               wrap;
    logic               is_put;
    logic               sweep_last;

    assign is_put    = (r_cmd.kind == tcw_pkg::K_PUT_CURSOR) || (r_cmd.kind == tcw_pkg::K_PUT_CELL);
    assign src_row   = (r_cmd.kind == tcw_pkg::K_PUT_CELL) ? RW'(r_cmd.row_index) : r_row;
    assign src_col   = (r_cmd.kind == tcw_pkg::K_PUT_CELL) ? CW'(r_cmd.column) : r_col;
    assign src_base  = (r_cmd.kind == tcw_pkg::K_PUT_CELL) ? r_tbase : r_base;
    assign step_line = r_cmd.is_newline || (src_col == COL_LAST);
    assign wrap      = is_put && step_line && (src_row == ROW_LAST);
    assign load_out  = (r_state == tcw_pkg::BS_DONE) && (!r_out_valid || !i_out_stall);
    assign sweep_last = (r_ptr == ADDR_LAST);

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::BS_INIT: begin
                if (sweep_last) n_state = tcw_pkg::BS_IDLE;
            end
            tcw_pkg::BS_IDLE: begin
                if (i_cmd_valid) n_state = tcw_pkg::BS_EXEC;
            end
            tcw_pkg::BS_EXEC: begin
                if (wrap) begin
                    n_state = tcw_pkg::BS_SCROLL;
                end else if (r_cmd.kind == tcw_pkg::K_CLEAR) begin
                    n_state = tcw_pkg::BS_CLEAR;
                end else begin
                    n_state = tcw_pkg::BS_DONE;
                end
            end
            tcw_pkg::BS_SCROLL: begin
                if (sweep_last) n_state = tcw_pkg::BS_SWEEP_END;
            end
            tcw_pkg::BS_SWEEP_END: n_state = tcw_pkg::BS_DONE;
            tcw_pkg::BS_CLEAR: begin
                if (sweep_last) n_state = tcw_pkg::BS_DONE;
            end
            tcw_pkg::BS_DONE: begin
                if (load_out) n_state = tcw_pkg::BS_IDLE;
            end
            default: n_state = tcw_pkg::BS_INIT;
        endcase
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_row      = r_row;
        n_col      = r_col;
        n_base     = r_base;
        n_tbase    = r_tbase;
        n_ptr      = r_ptr;
        n_is_read  = r_is_read;
        n_scrolled = r_scrolled;
        n_d_valid  = (r_state == tcw_pkg::BS_SCROLL);
        n_d_addr   = r_ptr;
        n_d_copy   = (r_ptr < LAST_BASE);
        o_cmd_pop  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_ptr + ROW_STEP;
        char_we    = r_d_valid;
        char_waddr = r_d_addr;
        char_wdata = r_d_copy ? r_rd_char : 8'd0;
        attr_we    = r_d_valid && r_d_copy;
        attr_waddr = r_d_addr;
        attr_wdata = r_rd_attr;
        case (r_state)
            tcw_pkg::BS_INIT: begin
                char_we    = 1'b1;
                char_waddr = r_ptr;
                char_wdata = 8'd0;
                attr_we    = 1'b1;
                attr_waddr = r_ptr;
                attr_wdata = 8'd0;
                n_ptr      = sweep_last ? '0 : r_ptr + AW'(1);
            end
            tcw_pkg::BS_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                n_cmd     = i_cmd;
                n_tbase   = AW'(i_cmd.row_index) * ROW_STEP;
            end
            tcw_pkg::BS_EXEC: begin
                n_is_read  = 1'b0;
                n_scrolled = 1'b0;
                case (r_cmd.kind)
                    tcw_pkg::K_PUT_CURSOR, tcw_pkg::K_PUT_CELL: begin
                        char_we    = !r_cmd.is_newline;
                        char_waddr = src_base + AW'(src_col);
                        char_wdata = r_cmd.char_code;
                        if (wrap) begin
                            n_row      = ROW_LAST;
                            n_col      = '0;
                            n_base     = LAST_BASE;
                            n_scrolled = 1'b1;
                            n_ptr      = '0;
                        end else if (step_line) begin
                            n_row  = src_row + RW'(1);
                            n_col  = '0;
                            n_base = src_base + ROW_STEP;
                        end else begin
                            n_row  = src_row;
                            n_col  = src_col + CW'(1);
                            n_base = src_base;
                        end
                    end
                    tcw_pkg::K_BACKSPACE: begin
                        if (r_row != '0 || r_col != '0) begin
                            char_we    = 1'b1;
                            char_waddr = r_base + AW'(r_col) - AW'(1);
                            char_wdata = 8'd0;
                            if (r_col == '0) begin
                                n_row  = r_row - RW'(1);
                                n_col  = COL_LAST;
                                n_base = r_base - ROW_STEP;
                            end else begin
                                n_col = r_col - CW'(1);
                            end
                        end
                    end
                    tcw_pkg::K_COLOR: begin
                        attr_we    = 1'b1;
                        attr_waddr = r_tbase + AW'(CW'(r_cmd.column));
                        attr_wdata = r_cmd.attribute;
                    end
                    tcw_pkg::K_CLEAR: begin
                        n_row  = '0;
                        n_col  = '0;
                        n_base = '0;
                        n_ptr  = '0;
                    end
                    tcw_pkg::K_READ: begin
                        rd_en     = 1'b1;
                        rd_addr   = r_tbase + AW'(CW'(r_cmd.column));
                        n_is_read = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            tcw_pkg::BS_SCROLL: begin
                rd_en = (r_ptr < LAST_BASE);
                n_ptr = sweep_last ? '0 : r_ptr + AW'(1);
            end
            tcw_pkg::BS_CLEAR: begin
                char_we    = 1'b1;
                char_waddr = r_ptr;
                char_wdata = 8'd0;
                n_ptr      = sweep_last ? '0 : r_ptr + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::BS_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_ptr       <= '0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_ptr       <= n_ptr;
            r_d_valid   <= n_d_valid;
            r_out_valid <= load_out || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_tbase    <= n_tbase;
        r_d_copy   <= n_d_copy;
        r_d_addr   <= n_d_addr;
        r_is_read  <= n_is_read;
        r_scrolled <= n_scrolled;
        if (load_out) begin
            r_out.cursor_column <= 7'(r_col);
            r_out.cursor_row    <= 5'(r_row);
            r_out.cell_char     <= r_is_read ? r_rd_char : 8'd0;
            r_out.cell_attr     <= r_is_read ? r_rd_attr : 8'd0;
            r_out.scrolled      <= r_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (char_we) begin
            r_mem_char[char_waddr] <= char_wdata;
        end
        if (attr_we) begin
            r_mem_attr[attr_waddr] <= attr_wdata;
        end
        if (rd_en) begin
            r_rd_char <= r_mem_char[rd_addr];
            r_rd_attr <= r_mem_attr[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: hdl/text_console_writer.sv
// Top level of the text console writer: front end with command queue and
// back end with cell memories and sequencer.
// Depends on tcw_pkg, tcw_front and tcw_back.
//
//   channel   direction  signals                        accepted when
//   input     in         i_in_valid o_in_stall i_in_item  valid && !stall
//   output    out        o_out_valid i_out_stall o_out_item valid && !stall
//   config    in         i_cfg_wr_en i_cfg_wr_data       wr_en high
//
// An accepted item is popped by the sequencer in IDLE, executed in EXEC and its
// result loaded into the output register in DONE; the back end's single sequencer
// takes no new item until that result is loaded. Clear and scroll sweep all
// COLUMNS*ROWS cells, one cell per cycle through the memory ports.
// After reset a clearing pass over all COLUMNS*ROWS cells (2000 by default) runs
// first; the queue takes up to two items meanwhile, then stalls the input.
// A stalled output holds its item; the queue keeps taking items until full.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcw_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcw_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data
);

    logic          cmd_valid;
    logic          cmd_pop;
    tcw_pkg::t_cmd cmd;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: hdl/tcw_checker.sv
// Port-level checker for the text console writer and its bind statement.
// Depends on tcw_pkg and text_console_writer.
module tcw_port_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input tcw_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tcw_pkg::t_out_item o_out_item
);

    localparam logic [4:0] ROW_LAST_OUT = 5'(ROWS - 1);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input item dropped or changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item dropped or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item valid after reset");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_item.cursor_column) < COLUMNS)
                     && (32'(o_out_item.cursor_row) < ROWS))
        else $error("cursor off the grid");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.scrolled |->
            o_out_item.cursor_column == 7'd0 && o_out_item.cursor_row == ROW_LAST_OUT
            && o_out_item.cell_char == 8'd0 && o_out_item.cell_attr == 8'd0)
        else $error("scroll left cursor or read data wrong");

endmodule

bind text_console_writer tcw_port_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_in_item     (i_in_item),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_item    (o_out_item)
);

// File: tb/sv/tcw_checker.sv
// Checker for the text console writer: keeps its own copy of the screen,
// cursor and default attribute, predicts one result per accepted item and
// compares it with the block's output. Depends on tcw_pkg.
module tcw_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  tcw_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  tcw_pkg::t_out_item  i_out_item,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int CELLS      = COLUMNS_DEF * ROWS_DEF;
    localparam int MAX_REPORT = 100;

    logic [15:0] screen [CELLS];
    int unsigned cursor;
    logic [7:0]  blank_attr;
    t_out_item   expected_q [$];
    int          fails = 0;

    function automatic bit locate(t_in_item it, output int unsigned pos);
        pos = 0;
        if (it.column >= COLUMNS_DEF || it.row_index >= ROWS_DEF) return 1'b0;
        pos = it.row_index * COLUMNS_DEF + it.column;
        return 1'b1;
    endfunction

    // Write or advance from a cell, then scroll up one row if the cursor ran off the end.
    function automatic bit write_char(int unsigned pos, logic [7:0] ch);
        if (ch == NEWLINE_CODE) begin
            cursor = (pos / COLUMNS_DEF + 1) * COLUMNS_DEF;
        end else begin
            screen[pos][7:0] = ch;
            cursor = pos + 1;
        end
        if (cursor < CELLS) return 1'b0;
        for (int i = 0; i < CELLS - COLUMNS_DEF; i++) screen[i] = screen[i + COLUMNS_DEF];
        for (int i = CELLS - COLUMNS_DEF; i < CELLS; i++) screen[i][7:0] = 8'h00;
        cursor -= COLUMNS_DEF;
        return 1'b1;
    endfunction

    function automatic t_out_item console_step(t_in_item it);
        t_out_item   r;
        int unsigned pos;
        r = '0;
        case (it.opcode)
            OP_PUT_CURSOR: begin
                r.scrolled = write_char(cursor, it.char_code);
            end
            OP_PUT_CELL: begin
                if (locate(it, pos)) r.scrolled = write_char(pos, it.char_code);
            end
            OP_BACKSPACE: begin
                if (cursor > 0) begin
                    cursor -= 1;
                    screen[cursor][7:0] = 8'h00;
                end
            end
            OP_COLOR: begin
                if (locate(it, pos))
                    screen[pos][15:8] = (it.attribute == 8'h00) ? blank_attr : it.attribute;
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen[i][7:0] = 8'h00;
                cursor = 0;
            end
            OP_READ: begin
                if (locate(it, pos)) begin
                    r.cell_char = screen[pos][7:0];
                    r.cell_attr = screen[pos][15:8];
                end
            end
            default: begin
            end
        endcase
        r.cursor_column = 7'(cursor % COLUMNS_DEF);
        r.cursor_row    = 5'(cursor / COLUMNS_DEF);
        return r;
    endfunction

    task automatic compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            fails++;
            if (fails <= MAX_REPORT)
                $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) screen[i] = 16'h0000;
            cursor     = 0;
            blank_attr = DEFAULT_ATTR_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) blank_attr = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) expected_q.push_back(console_step(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORT)
                        $display("%0t: result expected none, actual %h", $time, i_out_item);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("cursor_column", want.cursor_column, i_out_item.cursor_column);
                    compare_field("cursor_row", want.cursor_row, i_out_item.cursor_row);
                    compare_field("cell_char", want.cell_char, i_out_item.cell_char);
                    compare_field("cell_attr", want.cell_attr, i_out_item.cell_attr);
                    compare_field("scrolled", want.scrolled, i_out_item.scrolled);
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the text console writer: clock, reset, command stimulus
// with random idling on both channels, default attribute writes and verdict.
// Depends on tcw_pkg, text_console_writer and tcw_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int QUIET_LIMIT   = 30000;
    localparam int PHASE_ITEMS   = 170;
    localparam int BURST_ITEMS   = 34;
    localparam int MAX_IDLE      = 12;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    t_in_item   in_item     = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       out_stall   = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    int         fail_count;
    int         pending;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;
    int unsigned max_gap      = MAX_IDLE;
    int unsigned max_stall    = MAX_IDLE;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_console_writer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    tcw_checker console_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Hold stall for a random count of cycles after each accepted result.
    always @(posedge clk) begin
        int unsigned n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            n = $urandom_range(0, max_stall);
            stall_left <= n;
            out_stall  <= (n != 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item cmd(logic [2:0] op, logic [7:0] ch, int col, int row,
                                     logic [7:0] attr);
        t_in_item it;
        it.opcode    = op;
        it.char_code = ch;
        it.column    = 7'(col);
        it.row_index = 5'(row);
        it.attribute = attr;
        return it;
    endfunction

    function automatic t_in_item random_command();
        t_in_item    it;
        int unsigned pick;
        it.char_code = 8'($urandom_range(0, 255));
        it.column    = 7'($urandom_range(0, COLUMNS_DEF - 1));
        it.row_index = 5'($urandom_range(0, ROWS_DEF - 1));
        it.attribute = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
            it.column    = 7'($urandom_range(0, 127));
            it.row_index = 5'($urandom_range(0, 31));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.opcode = OP_PUT_CURSOR;
            if ($urandom_range(0, 3) == 0) it.char_code = NEWLINE_CODE;
        end else if (pick < 55) begin
            it.opcode = OP_PUT_CELL;
            if ($urandom_range(0, 3) == 0) it.char_code = NEWLINE_CODE;
            if ($urandom_range(0, 2) == 0) it.row_index = 5'(ROWS_DEF - 1);
            if ($urandom_range(0, 3) == 0) it.column = 7'(COLUMNS_DEF - 1);
        end else if (pick < 65) begin
            it.opcode = OP_BACKSPACE;
        end else if (pick < 77) begin
            it.opcode = OP_COLOR;
            if ($urandom_range(0, 5) == 0) it.attribute = 8'h00;
        end else if (pick < 95) begin
            it.opcode = OP_READ;
        end else if (pick < 97) begin
            it.opcode = OP_CLEAR;
        end else begin
            it.opcode = ($urandom_range(0, 1) == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
        end
        return it;
    endfunction

    task automatic send(t_in_item it);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_default_attr(logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [7:0] attr_settings [5];
        attr_settings[0] = 8'h00;
        attr_settings[1] = 8'hFF;
        attr_settings[2] = 8'h01;
        attr_settings[3] = 8'($urandom_range(0, 255));
        attr_settings[4] = 8'h80;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send(cmd(OP_PUT_CURSOR, 8'h41, 0, 0, 8'h00));
        send(cmd(OP_PUT_CURSOR, 8'hFF, 0, 0, 8'h00));
        send(cmd(OP_PUT_CURSOR, 8'h00, 0, 0, 8'h00));
        send(cmd(OP_PUT_CURSOR, NEWLINE_CODE, 0, 0, 8'h00));
        send(cmd(OP_BACKSPACE, 8'h00, 0, 0, 8'h00));
        send(cmd(OP_READ, 8'h00, 0, 0, 8'h00));
        send(cmd(OP_COLOR, 8'h00, 0, 0, 8'h00));
        send(cmd(OP_READ, 8'h00, 0, 0, 8'h00));
        send(cmd(OP_COLOR, 8'h00, COLUMNS_DEF - 1, ROWS_DEF - 1, 8'hFF));
        send(cmd(OP_READ, 8'h00, COLUMNS_DEF - 1, ROWS_DEF - 1, 8'h00));
        send(cmd(OP_COLOR, 8'h00, COLUMNS_DEF, 0, 8'h12));
        send(cmd(OP_COLOR, 8'hFF, 127, 31, 8'h34));
        send(cmd(OP_READ, 8'h00, COLUMNS_DEF, ROWS_DEF - 1, 8'h00));
        send(cmd(OP_READ, 8'h00, 0, ROWS_DEF, 8'h00));
        send(cmd(OP_PUT_CELL, 8'h55, 127, 0, 8'h00));
        send(cmd(OP_PUT_CELL, 8'h5A, COLUMNS_DEF - 1, ROWS_DEF - 1, 8'h00));
        send(cmd(OP_READ, 8'h00, COLUMNS_DEF - 1, ROWS_DEF - 2, 8'h00));
        send(cmd(OP_PUT_CELL, NEWLINE_CODE, 5, ROWS_DEF - 1, 8'h00));
        send(cmd(OP_PUT_CELL, 8'h71, COLUMNS_DEF - 2, ROWS_DEF - 1, 8'h00));
        send(cmd(OP_PUT_CURSOR, 8'h72, 0, 0, 8'h00));
        send(cmd(OP_CLEAR, 8'h00, 0, 0, 8'h00));
        send(cmd(OP_BACKSPACE, 8'h00, 0, 0, 8'h00));
        send(cmd(OP_UNUSED_LO, 8'hFF, 127, 31, 8'hFF));
        send(cmd(OP_UNUSED_HI, 8'h00, 0, 0, 8'h00));
        send(cmd(OP_PUT_CELL, NEWLINE_CODE, 0, 0, 8'h00));

        foreach (attr_settings[p]) begin
            drain();
            write_default_attr(attr_settings[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % BURST_ITEMS == 0) begin
                    max_gap   = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
                    max_stall = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
                end
                send(random_command());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: text_console_writer.f
hdl/tcw_pkg.sv
hdl/tcw_front.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
hdl/tcw_checker.sv
tb/sv/tcw_checker.sv
tb/sv/tb_top.sv
